// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");
`define ASSERT_NEVER(name, clk, rst_n, expr) \
    `ASSERT_PROP(name, clk, rst_n, !(expr))
`else
`define ASSERT_PROP(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

// ----- rtl/dbw_pkg.sv -----
package dbw_pkg;

    localparam int SCREEN_WIDTH     = 480;
    localparam int SCREEN_HEIGHT    = 320;
    localparam int PIXELS_PER_BLOCK = 128;

    localparam int BLOCK_W  = 11;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam int BLOCK_LIMIT = (SCREEN_WIDTH * SCREEN_HEIGHT) / PIXELS_PER_BLOCK;

    localparam int OFFSET_W = (PIXELS_PER_BLOCK > 1) ? $clog2(PIXELS_PER_BLOCK) : 1;
    localparam int SEGW_W   = $clog2(PIXELS_PER_BLOCK + 1);
    localparam int XW       = $clog2(SCREEN_WIDTH);
    localparam int YW       = $clog2(SCREEN_HEIGHT + 1);
    localparam int COORD_W  = (XW > YW) ? XW : YW;

    // block*ppb split into row and column with a reciprocal multiply
    localparam int IDX_W     = $clog2(((1 << BLOCK_W) - 1) * PIXELS_PER_BLOCK + 1);
    localparam int DIV_SHIFT = IDX_W + XW;
    localparam longint DIV_MUL =
        ((longint'(1) << DIV_SHIFT) + longint'(SCREEN_WIDTH) - 1) / longint'(SCREEN_WIDTH);
    localparam longint BLOCK_MUL = DIV_MUL * longint'(PIXELS_PER_BLOCK);
    localparam int PROD_W    = BLOCK_W + $clog2(BLOCK_MUL + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
    localparam logic [7:0] CMD_NOP          = 8'h00;

    typedef struct packed {
        logic               open_win;
        logic               nop;
        logic [COORD_W-1:0] win_x;
        logic [COORD_W-1:0] win_end;
        logic [COORD_W-1:0] win_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } dbw_entry_t;

    typedef enum logic [3:0] {
        SLOT_COL_CMD,
        SLOT_XS_HI,
        SLOT_XS_LO,
        SLOT_XE_HI,
        SLOT_XE_LO,
        SLOT_PAGE_CMD,
        SLOT_YS_HI,
        SLOT_YS_LO,
        SLOT_YE_HI,
        SLOT_YE_LO,
        SLOT_MEMWR_CMD,
        SLOT_RED,
        SLOT_GREEN,
        SLOT_BLUE,
        SLOT_NOP
    } dbw_slot_t;

endpackage

// ----- rtl/dbw_front.sv -----
module dbw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dbw_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          wr_valid,
    input  logic                          wr_ready,
    output dbw_pkg::dbw_entry_t           wr_entry
);

    localparam int OW  = dbw_pkg::OFFSET_W;
    localparam int SW  = dbw_pkg::SEGW_W;
    localparam int XW  = dbw_pkg::XW;
    localparam int CW  = dbw_pkg::COORD_W;
    localparam int IW  = dbw_pkg::IDX_W;
    localparam int PW  = dbw_pkg::PROD_W;
    localparam int BW  = dbw_pkg::BLOCK_W;
    localparam int PPB = dbw_pkg::PIXELS_PER_BLOCK;

    logic          advance;
    logic          in_fire;
    logic [BW-1:0] blk;

    logic [OW-1:0] pix_off_reg, pix_off_next;

    // stage 1: products
    logic          s1_v_reg;
    logic [OW-1:0] s1_p_reg;
    logic [PW-1:0] s1_prod_reg;
    logic [IW-1:0] s1_idx_reg;
    logic          s1_ok_reg;
    logic [7:0]    s1_red_reg, s1_green_reg, s1_blue_reg;

    // stage 2: row and column
    logic          s2_v_reg;
    logic [OW-1:0] s2_p_reg;
    logic [CW-1:0] s2_q_reg;
    logic [XW-1:0] s2_r_reg;
    logic          s2_ok_reg;
    logic [7:0]    s2_red_reg, s2_green_reg, s2_blue_reg;

    logic [PW-1:0] q_wide;
    logic [CW-1:0] q_next;
    logic [IW-1:0] qw_prod;
    logic [IW-1:0] rem;

    // current block
    logic [XW-1:0] col_reg;
    logic [CW-1:0] row_reg;
    logic [SW-1:0] segw_reg;
    logic          ok_reg;

    logic          first;
    logic [XW:0]   room;
    logic [SW-1:0] segw_new;
    logic [XW-1:0] x_eff;
    logic [CW-1:0] y_eff;
    logic [SW-1:0] segw_eff;
    logic          ok_eff;
    logic          open2;
    logic [SW-1:0] p_ext;
    logic [SW-1:0] p_inc;
    logic [CW:0]   end_sum;

    assign blk     = s_tdata[BW-1:0];
    assign advance = !(s2_v_reg && ok_eff && !wr_ready);
    assign s_tready = advance;
    assign in_fire  = s_tvalid && advance;

    assign pix_off_next = (pix_off_reg == OW'(PPB - 1)) ? '0 : pix_off_reg + OW'(1);

    assign q_wide  = s1_prod_reg >> dbw_pkg::DIV_SHIFT;
    assign q_next  = CW'(q_wide);
    assign qw_prod = IW'(IW'(q_next) * IW'(dbw_pkg::SCREEN_WIDTH));
    assign rem     = s1_idx_reg - qw_prod;

    always_comb
    begin
        first    = (s2_p_reg == '0);
        room     = (XW+1)'(dbw_pkg::SCREEN_WIDTH) - (XW+1)'(s2_r_reg);
        segw_new = (room < (XW+1)'(PPB)) ? SW'(room) : SW'(PPB);
        x_eff    = first ? s2_r_reg  : col_reg;
        y_eff    = first ? s2_q_reg  : row_reg;
        segw_eff = first ? segw_new  : segw_reg;
        ok_eff   = first ? s2_ok_reg : ok_reg;
        p_ext    = SW'(s2_p_reg);
        p_inc    = p_ext + SW'(1);
        open2    = (p_ext == segw_eff) && (segw_eff < SW'(PPB));
        end_sum  = (CW+1)'(x_eff) + (CW+1)'(segw_eff) - (CW+1)'(1);

        wr_entry.open_win = first || open2;
        wr_entry.nop      = (p_inc == segw_eff) || (p_inc == SW'(PPB));
        // second window restarts at column 0 of the next row
        wr_entry.win_x    = open2 ? '0 : CW'(x_eff);
        wr_entry.win_end  = open2 ? CW'(SW'(PPB) - segw_eff - SW'(1)) : CW'(end_sum);
        wr_entry.win_y    = open2 ? y_eff + CW'(1) : y_eff;
        wr_entry.red      = s2_red_reg;
        wr_entry.green    = s2_green_reg;
        wr_entry.blue     = s2_blue_reg;
    end

    assign wr_valid = s2_v_reg && ok_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_off_reg <= '0;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            segw_reg    <= '0;
            ok_reg      <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                pix_off_reg <= pix_off_next;
            end
            if (advance)
            begin
                s1_v_reg <= s_tvalid;
                s2_v_reg <= s1_v_reg;
                if (s2_v_reg && first)
                begin
                    col_reg  <= x_eff;
                    row_reg  <= y_eff;
                    segw_reg <= segw_eff;
                    ok_reg   <= ok_eff;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_p_reg     <= pix_off_reg;
            s1_prod_reg  <= PW'(blk) * PW'(dbw_pkg::BLOCK_MUL);
            s1_idx_reg   <= IW'(IW'(blk) * IW'(PPB));
            s1_ok_reg    <= (32'(blk) < 32'(dbw_pkg::BLOCK_LIMIT));
            s1_red_reg   <= s_tdata[BW +: 8];
            s1_green_reg <= s_tdata[BW+8 +: 8];
            s1_blue_reg  <= s_tdata[BW+16 +: 8];

            s2_p_reg     <= s1_p_reg;
            s2_q_reg     <= q_next;
            s2_r_reg     <= XW'(rem);
            s2_ok_reg    <= s1_ok_reg;
            s2_red_reg   <= s1_red_reg;
            s2_green_reg <= s1_green_reg;
            s2_blue_reg  <= s1_blue_reg;
        end
    end

endmodule

// ----- rtl/dbw_queue.sv -----
module dbw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  dbw_pkg::dbw_entry_t wr_entry,
    output logic                rd_valid,
    input  logic                rd_ready,
    output dbw_pkg::dbw_entry_t rd_entry
);

    localparam int DEPTH = dbw_pkg::QUEUE_DEPTH;
    localparam int PTRW  = dbw_pkg::QPTR_W;
    localparam int CNTW  = dbw_pkg::QCNT_W;

    dbw_pkg::dbw_entry_t mem [DEPTH];

    logic [PTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg, count_next;
    logic            push, pop;

    assign wr_ready = (count_reg != CNTW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ----- rtl/dbw_back.sv -----
module dbw_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_valid,
    output logic                          rd_ready,
    input  dbw_pkg::dbw_entry_t           rd_entry,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dbw_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    dbw_pkg::dbw_slot_t slot_reg, slot_next;
    dbw_pkg::dbw_slot_t eff_slot, adv_slot;

    logic        out_v_reg, out_v_next;
    logic [7:0]  byte_reg;
    logic        data_reg;
    logic        last_reg;

    logic        load;
    logic        is_last;
    logic [7:0]  byte_sel;
    logic        data_sel;
    logic [15:0] xs16, xe16, y16;

    assign xs16 = 16'(rd_entry.win_x);
    assign xe16 = 16'(rd_entry.win_end);
    assign y16  = 16'(rd_entry.win_y);

    assign load = rd_valid && (!out_v_reg || m_tready);

    always_comb
    begin
        // words without a window start at the pixel bytes
        eff_slot = slot_reg;
        if (!rd_entry.open_win && slot_reg == dbw_pkg::SLOT_COL_CMD)
        begin
            eff_slot = dbw_pkg::SLOT_RED;
        end

        byte_sel = dbw_pkg::CMD_NOP;
        data_sel = 1'b1;
        adv_slot = dbw_pkg::SLOT_COL_CMD;
        case (eff_slot)
            dbw_pkg::SLOT_COL_CMD:
            begin
                byte_sel = dbw_pkg::CMD_COLUMN_SET;
                data_sel = 1'b0;
                adv_slot = dbw_pkg::SLOT_XS_HI;
            end
            dbw_pkg::SLOT_XS_HI:
            begin
                byte_sel = xs16[15:8];
                adv_slot = dbw_pkg::SLOT_XS_LO;
            end
            dbw_pkg::SLOT_XS_LO:
            begin
                byte_sel = xs16[7:0];
                adv_slot = dbw_pkg::SLOT_XE_HI;
            end
            dbw_pkg::SLOT_XE_HI:
            begin
                byte_sel = xe16[15:8];
                adv_slot = dbw_pkg::SLOT_XE_LO;
            end
            dbw_pkg::SLOT_XE_LO:
            begin
                byte_sel = xe16[7:0];
                adv_slot = dbw_pkg::SLOT_PAGE_CMD;
            end
            dbw_pkg::SLOT_PAGE_CMD:
            begin
                byte_sel = dbw_pkg::CMD_PAGE_SET;
                data_sel = 1'b0;
                adv_slot = dbw_pkg::SLOT_YS_HI;
            end
            dbw_pkg::SLOT_YS_HI:
            begin
                byte_sel = y16[15:8];
                adv_slot = dbw_pkg::SLOT_YS_LO;
            end
            dbw_pkg::SLOT_YS_LO:
            begin
                byte_sel = y16[7:0];
                adv_slot = dbw_pkg::SLOT_YE_HI;
            end
            dbw_pkg::SLOT_YE_HI:
            begin
                byte_sel = y16[15:8];
                adv_slot = dbw_pkg::SLOT_YE_LO;
            end
            dbw_pkg::SLOT_YE_LO:
            begin
                byte_sel = y16[7:0];
                adv_slot = dbw_pkg::SLOT_MEMWR_CMD;
            end
            dbw_pkg::SLOT_MEMWR_CMD:
            begin
                byte_sel = dbw_pkg::CMD_MEMORY_WRITE;
                data_sel = 1'b0;
                adv_slot = dbw_pkg::SLOT_RED;
            end
            dbw_pkg::SLOT_RED:
            begin
                byte_sel = rd_entry.red;
                adv_slot = dbw_pkg::SLOT_GREEN;
            end
            dbw_pkg::SLOT_GREEN:
            begin
                byte_sel = rd_entry.green;
                adv_slot = dbw_pkg::SLOT_BLUE;
            end
            dbw_pkg::SLOT_BLUE:
            begin
                byte_sel = rd_entry.blue;
                adv_slot = dbw_pkg::SLOT_NOP;
            end
            dbw_pkg::SLOT_NOP:
            begin
                byte_sel = dbw_pkg::CMD_NOP;
                data_sel = 1'b0;
                adv_slot = dbw_pkg::SLOT_COL_CMD;
            end
            default:
            begin
                byte_sel = dbw_pkg::CMD_NOP;
                data_sel = 1'b0;
                adv_slot = dbw_pkg::SLOT_COL_CMD;
            end
        endcase

        is_last = (eff_slot == dbw_pkg::SLOT_NOP) ||
                  (eff_slot == dbw_pkg::SLOT_BLUE && !rd_entry.nop);

        slot_next = slot_reg;
        if (load)
        begin
            slot_next = is_last ? dbw_pkg::SLOT_COL_CMD : adv_slot;
        end

        out_v_next = out_v_reg;
        if (load)
        begin
            out_v_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_v_next = 1'b0;
        end
    end

    assign rd_ready = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= dbw_pkg::SLOT_COL_CMD;
            out_v_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_sel;
            data_reg <= data_sel;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- rtl/display_block_window_writer_core.sv -----
// channel   dir  tdata / tuser / tlast
// s_*       in   tdata: block_index[10:0] red[18:11] green[26:19] blue[34:27]
// m_*       out  tdata: link_byte[7:0]; tuser: is_data; tlast: last_of_run
//
// Output runs at one byte per cycle while m_tready is high, through a single registered
// byte lane: red, green, blue per pixel, a NOP at a segment end, and window setup bytes
// before a pixel that opens a window. Input passes two multiplier stages to the queue.
// A 4-word queue lets the input side keep taking pixels while the link stalls.
// Reset is asynchronous and clears all control state; no clearing pass.
`include "assert_macros.svh"

module display_block_window_writer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // block_index[10:0], red[18:11], green[26:19], blue[34:27], zero fill
    input  logic [dbw_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // link_byte[7:0]
    output logic [dbw_pkg::M_TDATA_W-1:0] m_tdata,
    // is_data[0]
    output logic                          m_tuser,
    output logic                          m_tlast
);

    logic                wr_valid, wr_ready;
    logic                rd_valid, rd_ready;
    dbw_pkg::dbw_entry_t wr_entry, rd_entry;
    logic                q_full;
    logic                q_pop;
    logic                last_ok;

    dbw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_entry (wr_entry)
    );

    dbw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_entry (wr_entry),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_entry (rd_entry)
    );

    dbw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_entry (rd_entry),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign q_full  = !wr_ready;
    assign q_pop   = rd_valid && rd_ready;
    assign last_ok = m_tuser || (m_tdata == dbw_pkg::CMD_NOP);

    // input only backs up when the queue is full
    `ASSERT_NEVER(a_stall_needs_full, clk, rst_n, !s_tready && !q_full)
    // retiring a queue word puts the closing byte of the pixel on the port
    `ASSERT_PROP(a_pop_gives_last, clk, rst_n, q_pop |=> (m_tvalid && m_tlast))
    // a closing byte is pixel data or the NOP command
    `ASSERT_PROP(a_last_kind, clk, rst_n, (m_tvalid && m_tlast) |-> last_ok)

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int PHASE_ITEMS      = 40;
    localparam int OFFSET_W         = dbw_pkg::OFFSET_W;
    localparam int SEGW_W           = dbw_pkg::SEGW_W;
    localparam int S_TDATA_W        = dbw_pkg::S_TDATA_W;
    localparam int M_TDATA_W        = dbw_pkg::M_TDATA_W;
    localparam int BLOCK_W          = dbw_pkg::BLOCK_W;
    localparam int BLOCK_LIMIT      = dbw_pkg::BLOCK_LIMIT;
    localparam int SCREEN_WIDTH     = dbw_pkg::SCREEN_WIDTH;
    localparam int PIXELS_PER_BLOCK = dbw_pkg::PIXELS_PER_BLOCK;

    typedef struct packed {
        logic [7:0] link_byte;
        logic       is_data;
        logic       last_of_run;
    } link_word_t;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // Predicts the command/data byte stream for each accepted pixel word.
    class window_byte_sb;
        link_word_t          pending[$];
        link_word_t          burst[$];
        int                  errors;
        logic [OFFSET_W-1:0] pixel_offset;
        logic [SEGW_W-1:0]   segment_width;
        logic [8:0]          start_column;
        logic [8:0]          start_row;
        logic                block_valid;

        function new();
            errors        = 0;
            pixel_offset  = '0;
            segment_width = '0;
            start_column  = '0;
            start_row     = '0;
            block_valid   = 1'b0;
        endfunction

        function void add_byte(logic [7:0] b, logic d);
            link_word_t w;
            w.link_byte   = b;
            w.is_data     = d;
            w.last_of_run = 1'b0;
            burst.push_back(w);
        endfunction

        // window coordinates go out as big-endian 16-bit halves
        function void add_half(logic [15:0] v);
            add_byte(v[15:8], 1'b1);
            add_byte(v[7:0], 1'b1);
        endfunction

        function void add_window(logic [15:0] x, logic [15:0] x_end, logic [15:0] y);
            add_byte(dbw_pkg::CMD_COLUMN_SET, 1'b0);
            add_half(x);
            add_half(x_end);
            add_byte(dbw_pkg::CMD_PAGE_SET, 1'b0);
            add_half(y);
            add_half(y);
            add_byte(dbw_pkg::CMD_MEMORY_WRITE, 1'b0);
        endfunction

        function void note_pixel(logic [S_TDATA_W-1:0] word);
            int p;
            int idx;
            int room;
            int segw;
            p = int'(pixel_offset);
            burst.delete();
            // block index only counts at the first pixel of a block
            if (p == 0)
            begin
                block_valid = (int'(word[BLOCK_W-1:0]) < BLOCK_LIMIT);
                if (block_valid)
                begin
                    idx           = int'(word[BLOCK_W-1:0]) * PIXELS_PER_BLOCK;
                    start_column  = 9'(idx % SCREEN_WIDTH);
                    start_row     = 9'(idx / SCREEN_WIDTH);
                    room          = SCREEN_WIDTH - int'(start_column);
                    segment_width = SEGW_W'((room < PIXELS_PER_BLOCK) ? room : PIXELS_PER_BLOCK);
                end
            end
            segw = int'(segment_width);
            if (block_valid)
            begin
                if (p == 0)
                    add_window(16'(start_column), 16'(int'(start_column) + segw - 1),
                               16'(start_row));
                // row wrap: second window at column 0 of the next row
                if (p == segw && segw < PIXELS_PER_BLOCK)
                    add_window(16'd0, 16'(PIXELS_PER_BLOCK - segw - 1),
                               16'(int'(start_row) + 1));
                add_byte(word[18:11], 1'b1);
                add_byte(word[26:19], 1'b1);
                add_byte(word[34:27], 1'b1);
                if (p + 1 == segw || p + 1 == PIXELS_PER_BLOCK)
                    add_byte(dbw_pkg::CMD_NOP, 1'b0);
                burst[burst.size()-1].last_of_run = 1'b1;
                pending = {pending, burst};
            end
            pixel_offset = (p + 1 >= PIXELS_PER_BLOCK) ? '0 : OFFSET_W'(p + 1);
        endfunction

        function void check_byte(logic [7:0] b, logic d, logic l);
            link_word_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: byte=%02h is_data=%0b last=%0b", b, d, l);
            end
            else
            begin
                want = pending.pop_front();
                if (want.link_byte !== b || want.is_data !== d || want.last_of_run !== l)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                                 want.link_byte, want.is_data, want.last_of_run, b, d, l);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    window_byte_sb sb = new();
    idle_mode_t    idle_mode = IDLE_NONE;
    int            items_sent = 0;
    int            quiet_cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    display_block_window_writer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // monitor, receiver stalls and watchdog
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_pixel(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tuser, m_tlast);
        if (rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        m_tready <= (idle_mode == IDLE_RECV) ? ($urandom_range(99) >= 58) :
                    (idle_mode == IDLE_BOTH) ? ($urandom_range(99) >= 11) : 1'b1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_pixel(logic [10:0] blk, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        idle_mode = idle_mode_t'((items_sent / PHASE_ITEMS) % 4);
        while ((idle_mode == IDLE_SEND && $urandom_range(99) < 58) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 11))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, b, g, r, blk};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // later pixels carry a random block index, which must be ignored
    task automatic send_block(logic [10:0] blk, bit directed, int count);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        for (int p = 0; p < count; p++)
        begin
            r = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
            if (directed && p == 0)
                {r, g, b} = 24'h000000;
            else if (directed && p == 1)
                {r, g, b} = 24'hFFFFFF;
            else if (directed && p == 2)
                {r, g, b} = 24'h80017F;
            send_pixel((p == 0) ? blk : 11'($urandom_range(2047)), r, g, b);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // wrap near the bottom row, then part of the largest index (dropped)
        send_block(11'd1196, 1'b1, PIXELS_PER_BLOCK);
        send_block(11'd2047, 1'b1, 42);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
